FILE: rtl/core/bstex_pkg.sv
`default_nettype none
package bstex_pkg;

	localparam int CFG_W = 9;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEX_WIDTH  = 2'd0,
		REG_TEX_HEIGHT = 2'd1,
		REG_HAS_ALPHA  = 2'd2
	} cfg_reg_t;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam int STAGES = 7;
	localparam int WGT_W = 33;
	localparam int PROD_W = 49;

	typedef struct packed {
		logic [STAGES:1] go;
		logic            mem_we;
	} pipe_ctl_t;

	typedef logic [15:0] rom_t [256];

	// srgb decode scaled to 16 bits: linear segment by rounded division, the rest found by exact integer search
	function automatic rom_t build_rom();
		logic [319:0] base;
		logic [319:0] rhs;
		logic [319:0] lhs;
		logic [16:0]  lo;
		logic [16:0]  hi;
		logic [16:0]  mid;
		rom_t         r;
		base = 320'd1;
		for (int k = 0; k < 12; k++) base = base * 320'd10761;
		for (int i = 0; i < 256; i++) begin
			if (i <= 10) begin
				r[i] = 16'((1310700 * i + 32946) / 65892);
			end else begin
				rhs = 320'd1;
				for (int k = 0; k < 12; k++) rhs = rhs * 320'(40 * i + 561);
				for (int k = 0; k < 5; k++) rhs = rhs * 320'd131070;
				lo = 17'd0;
				hi = 17'd65535;
				while (lo < hi) begin
					mid = (lo + hi + 17'd1) >> 1;
					lhs = base;
					for (int k = 0; k < 5; k++) lhs = lhs * (320'(mid) * 320'd2 - 320'd1);
					if (lhs <= rhs) lo = mid;
					else hi = mid - 17'd1;
				end
				r[i] = lo[15:0];
			end
		end
		return r;
	endfunction

	localparam rom_t SRGB_ROM = build_rom();

endpackage
`default_nettype wire

FILE: rtl/core/bilinear_srgb_texture_sampler.sv
// channel   | handshake           | payload
// request   | req_valid/req_stall | opcode, texel_index, texel_*, coord_u, coord_v
// result    | res_valid/res_stall | lin_red, lin_green, lin_blue, lin_alpha
// config    | cfg_we              | cfg_index, cfg_data
// one request per cycle while req_stall is low; a sample's result shows on the port from the last stage register
// a texel write passes stages 1 to 3 and lands in the store as it leaves stage 3, in request order
// four store copies give the four neighbour reads in the same cycle
// each stage holds only while it is full and the next one holds; bubbles close up
// reset clears valid bits and sets config registers to their defaults; the store is not cleared
`default_nettype none
module bilinear_srgb_texture_sampler #(
	parameter int MAX_SIDE = 256,
	parameter int STORE_TEXELS = 65536
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [bstex_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bstex_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                            req_valid,
	output logic                                 req_stall,
	input  wire logic                            opcode,
	input  wire logic [15:0]                     texel_index,
	input  wire logic [7:0]                      texel_red,
	input  wire logic [7:0]                      texel_green,
	input  wire logic [7:0]                      texel_blue,
	input  wire logic [7:0]                      texel_alpha,
	input  wire logic signed [31:0]              coord_u,
	input  wire logic signed [31:0]              coord_v,
	output logic                                 res_valid,
	input  wire logic                            res_stall,
	output logic [15:0]                          lin_red,
	output logic [15:0]                          lin_green,
	output logic [15:0]                          lin_blue,
	output logic [15:0]                          lin_alpha
);
	localparam int SIDE_W = $clog2(MAX_SIDE + 1);
	localparam int ADDR_W = $clog2(STORE_TEXELS);
	localparam logic [31:0] RST_SIDE = (256 > MAX_SIDE) ? 32'(MAX_SIDE) : 32'd256;

	logic [SIDE_W-1:0] w_q, h_q;
	logic              alpha_en_q;
	logic [31:0]       cfg_ext, side;

	logic [bstex_pkg::STAGES:1] v;
	logic [bstex_pkg::STAGES:1] go;
	bstex_pkg::pipe_ctl_t       ctl;

	logic                                 wr_s3;
	logic [ADDR_W-1:0]                    waddr_s3;
	logic [31:0]                          wdata_s3;
	logic [3:0][ADDR_W-1:0]               raddr_s3;
	logic [15:0]                          wu_s3, wv_s3;
	logic [3:0][31:0]                     texel_s4;
	logic [3:0][bstex_pkg::WGT_W-1:0]     wgt_s4;
	logic [3:0][15:0]                     lin_s7;

	assign cfg_ext = 32'(cfg_data);
	assign side = (cfg_ext == '0) ? 32'd1 : ((cfg_ext > 32'(MAX_SIDE)) ? 32'(MAX_SIDE) : cfg_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q        <= RST_SIDE[SIDE_W-1:0];
			h_q        <= RST_SIDE[SIDE_W-1:0];
			alpha_en_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bstex_pkg::REG_TEX_WIDTH:  w_q <= side[SIDE_W-1:0];
				bstex_pkg::REG_TEX_HEIGHT: h_q <= side[SIDE_W-1:0];
				bstex_pkg::REG_HAS_ALPHA:  alpha_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		go[bstex_pkg::STAGES] = !v[bstex_pkg::STAGES] || !res_stall;
		for (int k = bstex_pkg::STAGES - 1; k >= 1; k--) go[k] = !v[k] || go[k+1];
	end

	assign ctl.go = go;
	assign ctl.mem_we = go[4] && v[3] && wr_s3;
	assign req_stall = !go[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			if (go[1]) v[1] <= req_valid;
			if (go[2]) v[2] <= v[1];
			if (go[3]) v[3] <= v[2];
			if (go[4]) v[4] <= v[3] && !wr_s3;
			for (int k = 5; k <= bstex_pkg::STAGES; k++) begin
				if (go[k]) v[k] <= v[k-1];
			end
		end
	end

	bstex_coord #(.SIDE_W(SIDE_W), .ADDR_W(ADDR_W)) u_coord (
		.clk        (clk),
		.ctl        (ctl),
		.w          (w_q),
		.h          (h_q),
		.alpha_en   (alpha_en_q),
		.opcode     (opcode),
		.texel_index(texel_index),
		.texel_red  (texel_red),
		.texel_green(texel_green),
		.texel_blue (texel_blue),
		.texel_alpha(texel_alpha),
		.coord_u    (coord_u),
		.coord_v    (coord_v),
		.wr_s3      (wr_s3),
		.waddr_s3   (waddr_s3),
		.wdata_s3   (wdata_s3),
		.raddr_s3   (raddr_s3),
		.wu_s3      (wu_s3),
		.wv_s3      (wv_s3)
	);

	bstex_store #(.STORE_TEXELS(STORE_TEXELS), .ADDR_W(ADDR_W)) u_store (
		.clk     (clk),
		.ctl     (ctl),
		.waddr   (waddr_s3),
		.wdata   (wdata_s3),
		.raddr   (raddr_s3),
		.wu      (wu_s3),
		.wv      (wv_s3),
		.texel_s4(texel_s4),
		.wgt_s4  (wgt_s4)
	);

	bstex_blend u_blend (
		.clk   (clk),
		.ctl   (ctl),
		.texel (texel_s4),
		.wgt   (wgt_s4),
		.lin_s7(lin_s7)
	);

	assign res_valid = v[bstex_pkg::STAGES];
	assign lin_red   = lin_s7[0];
	assign lin_green = lin_s7[1];
	assign lin_blue  = lin_s7[2];
	assign lin_alpha = lin_s7[3];

endmodule
`default_nettype wire

FILE: rtl/core/bstex_coord.sv
`default_nettype none
module bstex_coord #(
	parameter int SIDE_W = 9,
	parameter int ADDR_W = 16
) (
	input  wire logic                  clk,
	input  wire bstex_pkg::pipe_ctl_t  ctl,
	input  wire logic [SIDE_W-1:0]     w,
	input  wire logic [SIDE_W-1:0]     h,
	input  wire logic                  alpha_en,
	input  wire logic                  opcode,
	input  wire logic [15:0]           texel_index,
	input  wire logic [7:0]            texel_red,
	input  wire logic [7:0]            texel_green,
	input  wire logic [7:0]            texel_blue,
	input  wire logic [7:0]            texel_alpha,
	input  wire logic signed [31:0]    coord_u,
	input  wire logic signed [31:0]    coord_v,
	output logic                       wr_s3,
	output logic [ADDR_W-1:0]          waddr_s3,
	output logic [31:0]                wdata_s3,
	output logic [3:0][ADDR_W-1:0]     raddr_s3,
	output logic [15:0]                wu_s3,
	output logic [15:0]                wv_s3
);
	localparam int SU_W = 17 + SIDE_W;

	logic                wr_s1, wr_s2;
	logic [ADDR_W-1:0]   waddr_s1, waddr_s2;
	logic [31:0]         wdata_s1, wdata_s2;
	logic [SU_W-1:0]     su_s1, sv_s1;
	logic [SIDE_W-1:0]   x0_s2, x1_s2, y0_s2, y1_s2;
	logic [15:0]         wu_s2, wv_s2;

	logic [31:0]         idx_ext;
	logic [16:0]         fv;
	logic [SIDE_W:0]     tu, tv;
	logic [SIDE_W-1:0]   x0, x1, y0, y1;
	logic [47:0]         row0, row1;
	logic [47:0]         a00, a10, a01, a11;

	assign idx_ext = 32'(texel_index);
	assign fv = 17'h10000 - 17'(coord_v[15:0]);

	// stage 1: scale fractions by texture size
	always_ff @(posedge clk) begin
		if (ctl.go[1]) begin
			wr_s1    <= (opcode == bstex_pkg::OP_WRITE);
			waddr_s1 <= idx_ext[ADDR_W-1:0];
			wdata_s1 <= {alpha_en ? texel_alpha : 8'hff, texel_blue, texel_green, texel_red};
			su_s1    <= SU_W'(coord_u[15:0]) * SU_W'(w) + SU_W'(32'd32768);
			sv_s1    <= SU_W'(fv) * SU_W'(h) + SU_W'(32'd32768);
		end
	end

	// stage 2: repeat wrap of the four neighbours
	assign tu = su_s1[SU_W-1:16];
	assign tv = sv_s1[SU_W-1:16];
	assign x0 = (tu == '0) ? w - SIDE_W'(1) : SIDE_W'(tu - (SIDE_W+1)'(1));
	assign y0 = (tv == '0) ? h - SIDE_W'(1) : SIDE_W'(tv - (SIDE_W+1)'(1));
	assign x1 = (x0 == w - SIDE_W'(1)) ? '0 : x0 + SIDE_W'(1);
	assign y1 = (y0 == h - SIDE_W'(1)) ? '0 : y0 + SIDE_W'(1);

	always_ff @(posedge clk) begin
		if (ctl.go[2]) begin
			wr_s2    <= wr_s1;
			waddr_s2 <= waddr_s1;
			wdata_s2 <= wdata_s1;
			x0_s2    <= x0;
			x1_s2    <= x1;
			y0_s2    <= y0;
			y1_s2    <= y1;
			wu_s2    <= su_s1[15:0];
			wv_s2    <= sv_s1[15:0];
		end
	end

	// stage 3: row-major addresses
	assign row0 = 48'(y0_s2) * 48'(w);
	assign row1 = 48'(y1_s2) * 48'(w);
	assign a00 = row0 + 48'(x0_s2);
	assign a10 = row0 + 48'(x1_s2);
	assign a01 = row1 + 48'(x0_s2);
	assign a11 = row1 + 48'(x1_s2);

	always_ff @(posedge clk) begin
		if (ctl.go[3]) begin
			wr_s3       <= wr_s2;
			waddr_s3    <= waddr_s2;
			wdata_s3    <= wdata_s2;
			raddr_s3[0] <= a00[ADDR_W-1:0];
			raddr_s3[1] <= a10[ADDR_W-1:0];
			raddr_s3[2] <= a01[ADDR_W-1:0];
			raddr_s3[3] <= a11[ADDR_W-1:0];
			wu_s3       <= wu_s2;
			wv_s3       <= wv_s2;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/bstex_store.sv
`default_nettype none
module bstex_store #(
	parameter int STORE_TEXELS = 65536,
	parameter int ADDR_W = 16
) (
	input  wire logic                              clk,
	input  wire bstex_pkg::pipe_ctl_t              ctl,
	input  wire logic [ADDR_W-1:0]                 waddr,
	input  wire logic [31:0]                       wdata,
	input  wire logic [3:0][ADDR_W-1:0]            raddr,
	input  wire logic [15:0]                       wu,
	input  wire logic [15:0]                       wv,
	output logic [3:0][31:0]                       texel_s4,
	output logic [3:0][bstex_pkg::WGT_W-1:0]       wgt_s4
);
	logic [16:0] iu, iv;

	// one copy of the store per neighbour, all written alike
	for (genvar g = 0; g < 4; g++) begin : g_bank
		logic [31:0] mem [STORE_TEXELS];
		always_ff @(posedge clk) begin
			if (ctl.mem_we) mem[waddr] <= wdata;
			if (ctl.go[4]) texel_s4[g] <= mem[raddr[g]];
		end
	end

	assign iu = 17'h10000 - 17'(wu);
	assign iv = 17'h10000 - 17'(wv);

	always_ff @(posedge clk) begin
		if (ctl.go[4]) begin
			wgt_s4[0] <= bstex_pkg::WGT_W'(iu) * bstex_pkg::WGT_W'(iv);
			wgt_s4[1] <= bstex_pkg::WGT_W'(wu) * bstex_pkg::WGT_W'(iv);
			wgt_s4[2] <= bstex_pkg::WGT_W'(iu) * bstex_pkg::WGT_W'(wv);
			wgt_s4[3] <= bstex_pkg::WGT_W'(wu) * bstex_pkg::WGT_W'(wv);
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/bstex_blend.sv
`default_nettype none
module bstex_blend (
	input  wire logic                              clk,
	input  wire bstex_pkg::pipe_ctl_t              ctl,
	input  wire logic [3:0][31:0]                  texel,
	input  wire logic [3:0][bstex_pkg::WGT_W-1:0]  wgt,
	output logic [3:0][15:0]                       lin_s7
);
	logic [3:0][bstex_pkg::WGT_W-1:0]  wgt_s5;
	logic [3:0][3:0][15:0]             val_s5;
	logic [3:0][3:0][bstex_pkg::PROD_W-1:0] prod_s6;
	logic [3:0][50:0]                  sum;

	// stage 5: decode colour bytes to linear; alpha byte is widened by replication
	always_ff @(posedge clk) begin
		if (ctl.go[5]) begin
			wgt_s5 <= wgt;
			for (int t = 0; t < 4; t++) begin
				for (int c = 0; c < 3; c++) begin
					val_s5[t][c] <= bstex_pkg::SRGB_ROM[texel[t][8*c +: 8]];
				end
				val_s5[t][3] <= {texel[t][31:24], texel[t][31:24]};
			end
		end
	end

	// stage 6: weight each neighbour
	always_ff @(posedge clk) begin
		if (ctl.go[6]) begin
			for (int t = 0; t < 4; t++) begin
				for (int c = 0; c < 4; c++) begin
					prod_s6[t][c] <= bstex_pkg::PROD_W'(val_s5[t][c])
						* bstex_pkg::PROD_W'(wgt_s5[t]);
				end
			end
		end
	end

	// stage 7: sum and round
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			sum[c] = 51'(prod_s6[0][c]) + 51'(prod_s6[1][c]) + 51'(prod_s6[2][c])
				+ 51'(prod_s6[3][c]) + 51'h8000_0000;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.go[7]) begin
			for (int c = 0; c < 4; c++) lin_s7[c] <= sum[c][47:32];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/bstex_checker.sv
`default_nettype none
module bstex_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            req_valid,
	input  wire logic                            req_stall,
	input  wire logic                            opcode,
	input  wire logic                            res_valid,
	input  wire logic                            res_stall,
	input  wire logic [15:0]                     lin_red,
	input  wire logic [15:0]                     lin_green,
	input  wire logic [15:0]                     lin_blue,
	input  wire logic [15:0]                     lin_alpha
);
	logic [3:0] pend_q;
	logic       take, give;

	assign take = req_valid && !req_stall && (opcode == bstex_pkg::OP_SAMPLE);
	assign give = res_valid && !res_stall;

	// samples taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pend_q <= '0;
		else pend_q <= pend_q + 4'(take) - 4'(give);
	end

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pend_q != 4'd0) else $error("result without sample");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 4'(bstex_pkg::STAGES)) else $error("too many samples in flight");

	a_free_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> !req_stall) else $error("request stalled with empty output");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(lin_red) && $stable(lin_green)
		&& $stable(lin_blue) && $stable(lin_alpha)) else $error("stalled result changed");

endmodule

bind bilinear_srgb_texture_sampler bstex_checker u_bstex_checker (.*);
`default_nettype wire

FILE: bench/tb_bilinear_srgb_texture_sampler.sv
module tb_bilinear_srgb_texture_sampler;

	typedef struct {
		logic        op;
		logic [15:0] idx;
		logic [7:0]  r, g, b, a;
		logic [31:0] u, v;
	} request_t;

	typedef struct {
		logic [15:0] r, g, b, a;
	} colour_t;

	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [bstex_pkg::CFG_IDX_W-1:0] cfg_index = bstex_pkg::REG_TEX_WIDTH;
	logic [bstex_pkg::CFG_W-1:0] cfg_data = '0;
	logic req_valid, req_stall, opcode;
	logic [15:0] texel_index;
	logic [7:0] texel_red, texel_green, texel_blue, texel_alpha;
	logic signed [31:0] coord_u, coord_v;
	logic res_valid, res_stall;
	logic [15:0] lin_red, lin_green, lin_blue, lin_alpha;

	request_t pending[$];
	colour_t expected_colours[$];
	logic [31:0] store_model [65536];
	bit filled [65536];
	logic [15:0] decode_lut [256];
	logic [8:0] width_reg = 9'd256, height_reg = 9'd256;
	logic alpha_reg = 1'b1;
	int errors = 0;
	int results_seen = 0;
	int burst_left = 0, gap_left = 0;
	int stall_mode = 0, mode_cycles = 0, hold_cycles = 0;
	bit long_hold_done = 0;
	int idle_cycles = 0;

	always #5 clk = ~clk;

	bilinear_srgb_texture_sampler dut (.*);

	function automatic int side(logic [8:0] s);
		if (s == 0) return 1;
		if (s > 256) return 256;
		return s;
	endfunction

	function automatic void fill_decode_lut();
		logic [319:0] denom, numer, trial;
		int lo, hi, mid;
		denom = 1;
		for (int k = 0; k < 12; k++) denom = denom * 320'd10761;
		for (int i = 0; i < 256; i++) begin
			if (i <= 10) begin
				decode_lut[i] = 16'((1310700 * i + 32946) / 65892);
			end else begin
				numer = 1;
				for (int k = 0; k < 12; k++) numer = numer * 320'(40 * i + 561);
				for (int k = 0; k < 5; k++) numer = numer * 320'd131070;
				lo = 0;
				hi = 65535;
				while (lo < hi) begin
					mid = (lo + hi + 1) / 2;
					trial = denom;
					for (int k = 0; k < 5; k++) trial = trial * 320'(2 * mid - 1);
					if (trial <= numer) lo = mid;
					else hi = mid - 1;
				end
				decode_lut[i] = 16'(lo);
			end
		end
	endfunction

	// the four neighbour addresses and the two weights of a sample
	function automatic void neighbours(logic [31:0] u, logic [31:0] v, output int addr[4],
			output longint unsigned wu, output longint unsigned wv);
		int w, h, x0, y0, x1, y1;
		longint unsigned su, sv;
		w = side(width_reg);
		h = side(height_reg);
		su = longint'(u[15:0]) * w + 32768;
		sv = (65536 - longint'(v[15:0])) * h + 32768;
		wu = su & 16'hffff;
		wv = sv & 16'hffff;
		x0 = int'(((su >> 16) + w - 1) % w);
		y0 = int'(((sv >> 16) + h - 1) % h);
		x1 = (x0 + 1) % w;
		y1 = (y0 + 1) % h;
		addr[0] = (y0 * w + x0) % 65536;
		addr[1] = (y0 * w + x1) % 65536;
		addr[2] = (y1 * w + x0) % 65536;
		addr[3] = (y1 * w + x1) % 65536;
	endfunction

	function automatic colour_t filter_sample(logic [31:0] u, logic [31:0] v);
		int addr[4];
		longint unsigned wu, wv, wt[4], acc, chan;
		logic [31:0] texel;
		logic [15:0] res[4];
		colour_t c;
		neighbours(u, v, addr, wu, wv);
		wt[0] = (65536 - wu) * (65536 - wv);
		wt[1] = wu * (65536 - wv);
		wt[2] = (65536 - wu) * wv;
		wt[3] = wu * wv;
		for (int ch = 0; ch < 4; ch++) begin
			acc = 0;
			for (int n = 0; n < 4; n++) begin
				texel = store_model[addr[n]];
				chan = (ch == 3) ? longint'(texel[31:24]) * 257 : decode_lut[texel[8*ch +: 8]];
				acc += chan * wt[n];
			end
			res[ch] = 16'((acc + 64'h8000_0000) >> 32);
		end
		c.r = res[0];
		c.g = res[1];
		c.b = res[2];
		c.a = res[3];
		return c;
	endfunction

	function automatic void apply_request(request_t q);
		if (q.op == bstex_pkg::OP_WRITE)
			store_model[q.idx] = {alpha_reg ? q.a : 8'hff, q.b, q.g, q.r};
		else
			expected_colours.push_back(filter_sample(q.u, q.v));
	endfunction

	function automatic request_t random_request(logic op);
		request_t q;
		q.op = op;
		q.idx = 16'($urandom);
		q.r = 8'($urandom);
		q.g = 8'($urandom);
		q.b = 8'($urandom);
		q.a = 8'($urandom);
		q.u = $urandom;
		q.v = $urandom;
		return q;
	endfunction

	function automatic void push_write(int idx, logic [7:0] r, logic [7:0] g, logic [7:0] b,
			logic [7:0] a);
		request_t q;
		q = random_request(bstex_pkg::OP_WRITE);
		q.idx = 16'(idx);
		q.r = r;
		q.g = g;
		q.b = b;
		q.a = a;
		filled[idx] = 1;
		pending.push_back(q);
	endfunction

	// a sample only after all four neighbours hold written texels
	function automatic void push_sample(logic [31:0] u, logic [31:0] v);
		int addr[4];
		longint unsigned wu, wv;
		request_t q;
		neighbours(u, v, addr, wu, wv);
		for (int n = 0; n < 4; n++)
			if (!filled[addr[n]])
				push_write(addr[n], 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		q = random_request(bstex_pkg::OP_SAMPLE);
		q.u = u;
		q.v = v;
		pending.push_back(q);
	endfunction

	task automatic report(string what, logic [15:0] got, logic [15:0] want);
		errors++;
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
	endtask

	task automatic wait_idle();
		while (pending.size() != 0 || expected_colours.size() != 0 || req_valid)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(bstex_pkg::cfg_reg_t idx, logic [bstex_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			bstex_pkg::REG_TEX_WIDTH: width_reg = val;
			bstex_pkg::REG_TEX_HEIGHT: height_reg = val;
			default: alpha_reg = val[0];
		endcase
	endtask

	task automatic run_phase(int w, int h, bit al, int n);
		int area;
		wait_idle();
		write_reg(bstex_pkg::REG_TEX_WIDTH, bstex_pkg::CFG_W'(w));
		write_reg(bstex_pkg::REG_TEX_HEIGHT, bstex_pkg::CFG_W'(h));
		write_reg(bstex_pkg::REG_HAS_ALPHA, bstex_pkg::CFG_W'(al));
		area = side(bstex_pkg::CFG_W'(w)) * side(bstex_pkg::CFG_W'(h));
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0, 1: push_write($urandom_range(area - 1), 8'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom));
				2: push_write($urandom_range(65535), 8'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom));
				default: push_sample($urandom, $urandom);
			endcase
			if ($urandom_range(15) == 0) @(posedge clk);
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		request_t q;
		logic nv;
		if (!arst_n) begin
			req_valid <= 1'b0;
			opcode <= bstex_pkg::OP_WRITE;
			texel_index <= '0;
			texel_red <= '0;
			texel_green <= '0;
			texel_blue <= '0;
			texel_alpha <= '0;
			coord_u <= '0;
			coord_v <= '0;
		end else begin
			nv = req_valid;
			if (req_valid && !req_stall) begin
				apply_request(pending.pop_front());
				nv = 1'b0;
			end
			if (!(req_valid && req_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					nv = 1'b0;
				end else if (pending.size() != 0) begin
					q = pending[0];
					nv = 1'b1;
					opcode <= q.op;
					texel_index <= q.idx;
					texel_red <= q.r;
					texel_green <= q.g;
					texel_blue <= q.b;
					texel_alpha <= q.a;
					coord_u <= q.u;
					coord_v <= q.v;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(40);
						gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
					end
				end else begin
					nv = 1'b0;
				end
			end
			req_valid <= nv;
		end
	end

	// result monitor and stall pattern
	always @(posedge clk or negedge arst_n) begin
		colour_t c;
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				results_seen++;
				if (expected_colours.size() == 0) begin
					errors++;
					$display("unexpected result at %0t", $time);
				end else begin
					c = expected_colours.pop_front();
					if (lin_red !== c.r) report("lin_red", lin_red, c.r);
					if (lin_green !== c.g) report("lin_green", lin_green, c.g);
					if (lin_blue !== c.b) report("lin_blue", lin_blue, c.b);
					if (lin_alpha !== c.a) report("lin_alpha", lin_alpha, c.a);
				end
			end
			if (!long_hold_done && results_seen >= 300) begin
				long_hold_done = 1;
				hold_cycles = 300;
			end
			if (mode_cycles == 0) begin
				mode_cycles = $urandom_range(20, 80);
				stall_mode = $urandom_range(2);
			end
			mode_cycles--;
			if (hold_cycles > 0) begin
				hold_cycles--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= (stall_mode == 0) ? 1'b0 :
					(stall_mode == 1) ? ($urandom_range(4) == 0) : ($urandom_range(3) != 0);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (res_valid && !res_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		logic [31:0] edge_coords[6];
		fill_decode_lut();
		edge_coords = '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
			32'h0000_8000, 32'hffff_0000};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		run_phase(4, 4, 1, 0);
		push_write(0, 8'd0, 8'd255, 8'd10, 8'd0);
		push_write(1, 8'd11, 8'd255, 8'd0, 8'd255);
		push_write(65535, 8'd255, 8'd128, 8'd1, 8'd77);
		for (int i = 2; i < 16; i++)
			push_write(i, 8'(i * 17), 8'(255 - i), 8'(i), 8'(i * 16));
		foreach (edge_coords[i]) push_sample(edge_coords[i], edge_coords[5 - i]);
		push_sample(32'h0000_2000, 32'h0000_6000);
		push_sample(32'h8000_ffff, 32'h7fff_0001);
		run_phase(4, 4, 1, 150);
		run_phase(1, 1, 0, 60);
		run_phase(256, 1, 1, 150);
		run_phase(1, 256, 0, 150);
		run_phase(0, 511, 1, 60);
		run_phase(511, 0, 0, 60);
		for (int p = 0; p < 6; p++)
			run_phase($urandom_range(1, 16), $urandom_range(1, 16), 1'($urandom), 120);
		wait_idle();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/bstex_pkg.sv
rtl/core/bstex_coord.sv
rtl/core/bstex_store.sv
rtl/core/bstex_blend.sv
rtl/core/bilinear_srgb_texture_sampler.sv
rtl/core/bstex_checker.sv
bench/tb_bilinear_srgb_texture_sampler.sv
